// ===== sv/acs3d_pkg.sv =====
package acs3d_pkg;

  localparam int MAX_ROWS_DEF    = 16;
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_SLICES_DEF  = 16;

  localparam int DIM_W   = 5;
  localparam int COORD_W = 4;
  localparam int INDEX_W = 12;
  localparam int TOTAL_W = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_SLICES  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    action_t             action;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_column;
    logic [COORD_W-1:0]  cell_slice;
    logic [INDEX_W-1:0]  list_index;
  } in_t;

  typedef struct packed {
    logic                status;
    logic                changed;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_column;
    logic [COORD_W-1:0]  out_slice;
    logic [TOTAL_W-1:0]  pending_total;
    logic [TOTAL_W-1:0]  committed_total;
  } out_t;

  typedef struct packed {
    action_t             action;
    logic                oob;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_column;
    logic [COORD_W-1:0]  cell_slice;
    logic [INDEX_W-1:0]  list_index;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] columns;
    logic [DIM_W-1:0] slices;
  } dims_t;

endpackage

// ===== sv/acs3d_queue.sv =====
module acs3d_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/acs3d_front.sv =====
module acs3d_front #(
  parameter int MAX_ROWS    = acs3d_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = acs3d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_SLICES  = acs3d_pkg::MAX_SLICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  acs3d_pkg::in_t                      request,
  output logic                                full,
  input  logic                                cfg_we,
  input  logic [acs3d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acs3d_pkg::DIM_W-1:0]         cfg_data,
  input  logic                                cmd_full,
  input  logic                                clearing,
  output logic                                cmd_push,
  output acs3d_pkg::cmd_t                     cmd,
  output acs3d_pkg::dims_t                    dims
);

  localparam int CW = 9;
  localparam int RESET_ROWS    = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int RESET_COLUMNS = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;
  localparam int RESET_SLICES  = (MAX_SLICES < 16) ? MAX_SLICES : 16;

  acs3d_pkg::dims_t dims_next;

  function automatic logic [acs3d_pkg::DIM_W-1:0] clamp(
    input logic [acs3d_pkg::DIM_W-1:0] v,
    input logic [CW-1:0]               maxv
  );
    logic [acs3d_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = acs3d_pkg::DIM_W'(1);
    end else if (CW'(v) > maxv) begin
      r = maxv[acs3d_pkg::DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    dims_next = dims;
    if (cfg_we) begin
      unique case (cfg_index)
        acs3d_pkg::CFG_ROWS:    dims_next.rows    = clamp(cfg_data, CW'(MAX_ROWS));
        acs3d_pkg::CFG_COLUMNS: dims_next.columns = clamp(cfg_data, CW'(MAX_COLUMNS));
        acs3d_pkg::CFG_SLICES:  dims_next.slices  = clamp(cfg_data, CW'(MAX_SLICES));
        default:                dims_next = dims;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows    <= acs3d_pkg::DIM_W'(RESET_ROWS);
      dims.columns <= acs3d_pkg::DIM_W'(RESET_COLUMNS);
      dims.slices  <= acs3d_pkg::DIM_W'(RESET_SLICES);
    end else begin
      dims <= dims_next;
    end
  end

  assign full     = cmd_full || clearing;
  assign cmd_push = push && !full;

  always_comb begin
    cmd.action      = request.action;
    cmd.cell_row    = request.cell_row;
    cmd.cell_column = request.cell_column;
    cmd.cell_slice  = request.cell_slice;
    cmd.list_index  = request.list_index;
    cmd.oob = ({1'b0, request.cell_row} >= dims.rows) ||
              ({1'b0, request.cell_column} >= dims.columns) ||
              ({1'b0, request.cell_slice} >= dims.slices);
  end

endmodule

// ===== sv/acs3d_back.sv =====
module acs3d_back #(
  parameter int MAX_ROWS    = acs3d_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = acs3d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_SLICES  = acs3d_pkg::MAX_SLICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  acs3d_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  input  acs3d_pkg::dims_t  dims,
  input  logic              res_full,
  output logic              res_push,
  output acs3d_pkg::out_t   res,
  output logic              clearing
);

  localparam int GRID  = MAX_ROWS * MAX_COLUMNS * MAX_SLICES;
  localparam int GA_W  = (GRID > 1) ? $clog2(GRID) : 1;
  localparam int CNT_W = $clog2(GRID + 1);
  localparam int CMP_W = (CNT_W > acs3d_pkg::INDEX_W) ? CNT_W : acs3d_pkg::INDEX_W;
  localparam int LE_W  = 3 * acs3d_pkg::COORD_W;
  localparam int CO_W  = acs3d_pkg::COORD_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RMW   = 6'b000100,
    ST_LREAD = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_t;

  state_t                      state, state_next;
  logic [GA_W-1:0]             clr_addr;
  logic [CNT_W-1:0]            pending, pending_next;
  logic [CNT_W-1:0]            committed, committed_next;
  logic                        op_add, op_add_next;
  logic [GA_W-1:0]             op_addr, op_addr_next;
  logic [acs3d_pkg::DIM_W-1:0] scan_r, scan_r_next;
  logic [acs3d_pkg::DIM_W-1:0] scan_c, scan_c_next;
  logic [acs3d_pkg::DIM_W-1:0] scan_s, scan_s_next;
  logic                        scan_v, scan_v_next;
  logic [LE_W-1:0]             scan_coord, scan_coord_next;
  logic [CNT_W-1:0]            fill, fill_next;

  logic                        flags [GRID];
  logic                        flag_rd;
  logic                        flag_we;
  logic                        flag_wdata;
  logic [GA_W-1:0]             flag_waddr;
  logic [GA_W-1:0]             flag_raddr;
  logic [LE_W-1:0]             list_mem [GRID];
  logic [LE_W-1:0]             list_rd;
  logic                        list_we;
  logic [GA_W-1:0]             cmd_addr;
  logic [GA_W-1:0]             scan_addr;
  logic                        rmw_changed;
  logic                        dispatch;
  logic                        res_status;
  logic                        res_changed;
  logic [LE_W-1:0]             res_coord;

  assign cmd_addr = GA_W'((int'(cmd.cell_row) * MAX_COLUMNS + int'(cmd.cell_column))
                          * MAX_SLICES + int'(cmd.cell_slice));
  assign scan_addr = GA_W'((int'(scan_r) * MAX_COLUMNS + int'(scan_c))
                           * MAX_SLICES + int'(scan_s));

  assign clearing    = (state == ST_CLEAR);
  assign dispatch    = (state == ST_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop     = dispatch;
  assign rmw_changed = op_add ? !flag_rd : flag_rd;
  assign flag_raddr  = (state == ST_SCAN) ? scan_addr : cmd_addr;
  assign list_we     = scan_v && flag_rd;

  always_comb begin
    flag_we    = 1'b0;
    flag_wdata = 1'b0;
    flag_waddr = op_addr;
    if (state == ST_CLEAR) begin
      flag_we    = 1'b1;
      flag_waddr = clr_addr;
    end else if (state == ST_RMW) begin
      flag_we    = rmw_changed;
      flag_wdata = op_add;
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flags[flag_waddr] <= flag_wdata;
    end
    flag_rd <= flags[flag_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[GA_W'(fill)] <= scan_coord;
    end
    list_rd <= list_mem[GA_W'(cmd.list_index)];
  end

  always_comb begin
    state_next      = state;
    pending_next    = pending;
    committed_next  = committed;
    op_add_next     = op_add;
    op_addr_next    = op_addr;
    scan_r_next     = scan_r;
    scan_c_next     = scan_c;
    scan_s_next     = scan_s;
    scan_v_next     = 1'b0;
    scan_coord_next = scan_coord;
    fill_next       = list_we ? fill + 1'b1 : fill;
    res_push        = 1'b0;
    res_status      = 1'b0;
    res_changed     = 1'b0;
    res_coord       = '0;

    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == GA_W'(GRID - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (dispatch) begin
          unique case (cmd.action) inside
            acs3d_pkg::ACT_ADD, acs3d_pkg::ACT_REMOVE: begin
              if (cmd.oob) begin
                res_push   = 1'b1;
                res_status = 1'b1;
              end else begin
                op_add_next  = (cmd.action == acs3d_pkg::ACT_ADD);
                op_addr_next = cmd_addr;
                state_next   = ST_RMW;
              end
            end
            acs3d_pkg::ACT_UPDATE: begin
              committed_next = pending;
              if (pending == '0) begin
                res_push = 1'b1;
              end else begin
                scan_r_next = '0;
                scan_c_next = '0;
                scan_s_next = '0;
                fill_next   = '0;
                state_next  = ST_SCAN;
              end
            end
            acs3d_pkg::ACT_READ: begin
              if (CMP_W'(cmd.list_index) >= CMP_W'(committed)) begin
                res_push   = 1'b1;
                res_status = 1'b1;
              end else begin
                state_next = ST_LREAD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RMW: begin
        res_push    = 1'b1;
        res_changed = rmw_changed;
        if (rmw_changed) begin
          pending_next = op_add ? pending + 1'b1 : pending - 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_LREAD: begin
        res_push   = 1'b1;
        res_coord  = list_rd;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        scan_v_next     = 1'b1;
        scan_coord_next = {CO_W'(scan_r), CO_W'(scan_c), CO_W'(scan_s)};
        if (scan_s == dims.slices - 1'b1) begin
          scan_s_next = '0;
          if (scan_c == dims.columns - 1'b1) begin
            scan_c_next = '0;
            if (scan_r == dims.rows - 1'b1) begin
              state_next = ST_DRAIN;
            end else begin
              scan_r_next = scan_r + 1'b1;
            end
          end else begin
            scan_c_next = scan_c + 1'b1;
          end
        end else begin
          scan_s_next = scan_s + 1'b1;
        end
      end
      ST_DRAIN: begin
        res_push   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res.status          = res_status;
    res.changed         = res_changed;
    res.out_row         = res_coord[LE_W-1 -: CO_W];
    res.out_column      = res_coord[2*CO_W-1 -: CO_W];
    res.out_slice       = res_coord[CO_W-1:0];
    res.pending_total   = acs3d_pkg::TOTAL_W'(pending_next);
    res.committed_total = acs3d_pkg::TOTAL_W'(committed_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pending   <= '0;
      committed <= '0;
      scan_v    <= 1'b0;
      fill      <= '0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr + 1'b1;
      pending   <= pending_next;
      committed <= committed_next;
      scan_v    <= scan_v_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    op_add     <= op_add_next;
    op_addr    <= op_addr_next;
    scan_r     <= scan_r_next;
    scan_c     <= scan_c_next;
    scan_s     <= scan_s_next;
    scan_coord <= scan_coord_next;
  end

endmodule

// ===== sv/active_cell_set_3d_core.sv =====
// Add and remove pass ST_RMW and read passes ST_LREAD in the execution unit, bound by the
// registered read of the flag or list memory and, for add and remove, the later flag write;
// rejected requests answer from ST_IDLE. An update scans rows_in_use * columns_in_use *
// slices_in_use flags, one flag a cycle, then ST_DRAIN; with nothing pending, from ST_IDLE.
// A result passes the command queue, execution unit and result queue. Reset is synchronous;
// afterwards all MAX_ROWS * MAX_COLUMNS * MAX_SLICES flags clear one a cycle, full high.
module active_cell_set_3d_core #(
  parameter int MAX_ROWS    = acs3d_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = acs3d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_SLICES  = acs3d_pkg::MAX_SLICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  acs3d_pkg::in_t                   request,
  output logic                             full,
  output logic                             empty,
  input  logic                             pop,
  output acs3d_pkg::out_t                  result,
  input  logic                             cfg_we,
  input  logic [acs3d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acs3d_pkg::DIM_W-1:0]      cfg_data
);

  localparam int CMD_W = $bits(acs3d_pkg::cmd_t);
  localparam int RES_W = $bits(acs3d_pkg::out_t);

  acs3d_pkg::cmd_t  cmd_in;
  acs3d_pkg::cmd_t  cmd_out;
  acs3d_pkg::dims_t dims;
  acs3d_pkg::out_t  res;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;
  logic             res_push;
  logic             res_full;
  logic             clearing;

  acs3d_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_SLICES  (MAX_SLICES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .request   (request),
    .full      (full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_full  (cmd_full),
    .clearing  (clearing),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .dims      (dims)
  );

  acs3d_queue #(
    .W     (CMD_W),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  acs3d_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_SLICES  (MAX_SLICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .dims      (dims),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  acs3d_queue #(
    .W     (RES_W),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== sv/acs3d_checker.sv =====
module acs3d_checker (
  input logic            clk,
  input logic            rst,
  input logic            full,
  input logic            empty,
  input logic            pop,
  input acs3d_pkg::out_t result
);

  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("full not raised during the clearing pass");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status) |->
      (!result.changed && result.out_row == '0 && result.out_column == '0 &&
       result.out_slice == '0))
    else $error("rejected request carries a change or coordinates");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before it was taken");

endmodule

bind active_cell_set_3d_core acs3d_checker u_acs3d_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
